### hdl/decimal_accumulator_alu_unit_defines.svh
// Assertion macros for the decimal accumulator core (dacc_core).
// Each expects clk and rst_n in the scope where it is used.
`ifndef DECIMAL_ACCUMULATOR_ALU_UNIT_DEFINES_SVH
`define DECIMAL_ACCUMULATOR_ALU_UNIT_DEFINES_SVH

// same-cycle implication
`define DACC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DACC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/dacc_pkg.sv
package dacc_pkg;

    localparam int DIGITS      = 16;
    localparam int DATA_W      = 64;
    localparam int ACC_W       = DIGITS * 4;
    localparam int WORK_DIGITS = DIGITS + 1;
    localparam int WORK_W      = WORK_DIGITS * 4;
    localparam int CNT_W       = $clog2(DIGITS + 1);
    localparam int CMD_W       = 3;
    localparam int STAT_W      = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CMP  = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVF  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NEG  = 2'd2;
    localparam logic [STAT_W-1:0] ST_DIV0 = 2'd3;

    localparam int CMP_LT = 2;
    localparam int CMP_EQ = 1;
    localparam int CMP_GT = 0;

    typedef struct packed {
        logic [ACC_W-1:0]  acc;
        logic [STAT_W-1:0] status;
        logic [2:0]        cmp;
        logic              zero;
    } dacc_res_t;

    // digits above nine read as zero, nibbles above the accumulator width dropped
    function automatic logic [ACC_W-1:0] bcd_clean(input logic [DATA_W-1:0] v);
        logic [ACC_W-1:0] r;
        r = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            r[4*i +: 4] = (v[4*i +: 4] > 4'd9) ? 4'd0 : v[4*i +: 4];
        end
        return r;
    endfunction

endpackage

### hdl/dacc_in_if.sv
interface dacc_in_if;
    import dacc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] operand;

    modport source (output valid, output cmd, output operand, input ready);
    modport sink   (input valid, input cmd, input operand, output ready);
endinterface

### hdl/dacc_out_if.sv
interface dacc_out_if;
    import dacc_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] acc_value;
    logic [STAT_W-1:0] status;
    logic              was_less;
    logic              was_equal;
    logic              was_greater;
    logic              acc_zero;

    modport source (
        output valid, output acc_value, output status, output was_less,
        output was_equal, output was_greater, output acc_zero, input ready
    );
    modport sink (
        input valid, input acc_value, input status, input was_less,
        input was_equal, input was_greater, input acc_zero, output ready
    );
endinterface

### hdl/decimal_accumulator_alu_unit.sv
// Decimal accumulator: 16-digit unsigned packed-BCD accumulator.
// cmd_ch carries a command (load, add, subtract, multiply, divide, compare)
// and a BCD operand; res_ch returns one word per command with the new
// accumulator, status, the three-way compare of old accumulator against
// operand, and a zero flag. A word is taken when valid and ready are high.
// One command is worked at a time on a shared BCD adder; cmd_ch.ready is
// high only while the sequencer is idle. Load, compare, a negative subtract
// and a divide by zero go straight to the result; add and subtract make one
// adder pass. Multiply shifts once per digit and runs one adder pass per unit
// of each operand digit; divide brings down each dividend digit and runs one
// trial subtract per quotient unit plus one per digit.
// A finished word waits in an output register, so the next command is taken
// while the receiver stalls; the sequencer holds the following result until
// that register frees. The accumulator updates when its result word moves
// to the output register. Reset clears the accumulator to zero and empties
// the output register.
module decimal_accumulator_alu_unit (
    input  logic        clk,
    input  logic        rst_n,
    dacc_in_if.sink     cmd_ch,
    dacc_out_if.source  res_ch
);
    import dacc_pkg::*;

    logic      out_valid_reg, out_valid_next;
    dacc_res_t out_res_reg,   out_res_next;
    dacc_res_t core_res;
    logic      core_idle;
    logic      core_valid;
    logic      res_take;

    assign res_take = core_valid && (!out_valid_reg || res_ch.ready);

    dacc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd_ch.valid),
        .cmd       (cmd_ch.cmd),
        .operand   (cmd_ch.operand),
        .res_take  (res_take),
        .idle      (core_idle),
        .res_valid (core_valid),
        .res       (core_res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_res_next   = core_res;
        end
        else if (res_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign cmd_ch.ready       = core_idle;
    assign res_ch.valid       = out_valid_reg;
    assign res_ch.acc_value   = DATA_W'(out_res_reg.acc);
    assign res_ch.status      = out_res_reg.status;
    assign res_ch.was_less    = out_res_reg.cmp[CMP_LT];
    assign res_ch.was_equal   = out_res_reg.cmp[CMP_EQ];
    assign res_ch.was_greater = out_res_reg.cmp[CMP_GT];
    assign res_ch.acc_zero    = out_res_reg.zero;
endmodule

### hdl/dacc_bcd_adder.sv
module dacc_bcd_adder (
    input  logic [dacc_pkg::WORK_W-1:0] x,
    input  logic [dacc_pkg::WORK_W-1:0] y,
    input  logic                        sub,
    output logic [dacc_pkg::WORK_W-1:0] sum,
    output logic                        cout
);
    import dacc_pkg::*;

    logic [WORK_DIGITS:0] carry;

    // subtract: nines' complement of y with carry in; carry out means x >= y
    assign carry[0] = sub;

    for (genvar i = 0; i < WORK_DIGITS; i++)
    begin : g_digit
        logic [3:0] yd;
        logic [4:0] raw;
        assign yd  = sub ? (4'd9 - y[4*i +: 4]) : y[4*i +: 4];
        assign raw = {1'b0, x[4*i +: 4]} + {1'b0, yd} + {4'b0000, carry[i]};
        assign carry[i+1] = (raw > 5'd9);
        assign sum[4*i +: 4] = carry[i+1] ? 4'(raw - 5'd10) : raw[3:0];
    end

    assign cout = carry[WORK_DIGITS];
endmodule

### hdl/dacc_core.sv
`include "decimal_accumulator_alu_unit_defines.svh"

module dacc_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [dacc_pkg::CMD_W-1:0]  cmd,
    input  logic [dacc_pkg::DATA_W-1:0] operand,
    input  logic                        res_take,
    output logic                        idle,
    output logic                        res_valid,
    output dacc_pkg::dacc_res_t         res
);
    import dacc_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ADD    = 3'd1;
    localparam logic [2:0] S_SUB    = 3'd2;
    localparam logic [2:0] S_MSHIFT = 3'd3;
    localparam logic [2:0] S_MADD   = 3'd4;
    localparam logic [2:0] S_DSHIFT = 3'd5;
    localparam logic [2:0] S_DSUB   = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]        state_reg,  state_next;
    logic [ACC_W-1:0]  acc_reg,    acc_next;
    logic [ACC_W-1:0]  b_reg,      b_next;
    logic [WORK_W-1:0] work_reg,   work_next;
    logic [ACC_W-1:0]  src_reg,    src_next;
    logic [ACC_W-1:0]  quot_reg,   quot_next;
    logic [3:0]        rep_reg,    rep_next;
    logic [CNT_W-1:0]  cnt_reg,    cnt_next;
    logic              ovf_reg,    ovf_next;
    logic [ACC_W-1:0]  res_reg,    res_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [2:0]        cmp_reg,    cmp_next;

    logic [ACC_W-1:0]  b_clean;
    logic [WORK_W-1:0] add_x, add_y, add_sum;
    logic              add_sub, add_cout;
    logic              commit;

    assign b_clean = bcd_clean(operand);
    assign commit  = (state_reg == S_DONE) && res_take;

    dacc_bcd_adder u_add (
        .x    (add_x),
        .y    (add_y),
        .sub  (add_sub),
        .sum  (add_sum),
        .cout (add_cout)
    );

    always_comb
    begin
        add_x   = work_reg;
        add_y   = WORK_W'(b_reg);
        add_sub = 1'b0;
        case (state_reg)
            S_ADD:
            begin
                add_x = WORK_W'(acc_reg);
            end
            S_SUB:
            begin
                add_x   = WORK_W'(acc_reg);
                add_sub = 1'b1;
            end
            S_MADD:
            begin
                add_y = WORK_W'(acc_reg);
            end
            S_DSUB:
            begin
                add_sub = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        b_next      = b_reg;
        work_next   = work_reg;
        src_next    = src_reg;
        quot_next   = quot_reg;
        rep_next    = rep_reg;
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        res_next    = res_reg;
        status_next = status_reg;
        cmp_next    = cmp_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    b_next      = b_clean;
                    work_next   = '0;
                    quot_next   = '0;
                    cnt_next    = '0;
                    ovf_next    = 1'b0;
                    rep_next    = '0;
                    src_next    = (cmd == CMD_DIV) ? acc_reg : b_clean;
                    res_next    = acc_reg;
                    status_next = ST_OK;
                    cmp_next[CMP_LT] = acc_reg < b_clean;
                    cmp_next[CMP_EQ] = acc_reg == b_clean;
                    cmp_next[CMP_GT] = acc_reg > b_clean;
                    state_next  = S_DONE;
                    case (cmd)
                        CMD_LOAD:
                        begin
                            res_next = b_clean;
                        end
                        CMD_ADD:
                        begin
                            state_next = S_ADD;
                        end
                        CMD_SUB:
                        begin
                            if (acc_reg < b_clean)
                                status_next = ST_NEG;
                            else
                                state_next = S_SUB;
                        end
                        CMD_MUL:
                        begin
                            state_next = S_MSHIFT;
                        end
                        CMD_DIV:
                        begin
                            if (b_clean == '0)
                                status_next = ST_DIV0;
                            else
                                state_next = S_DSHIFT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                if (add_sum[WORK_W-1 -: 4] != 4'd0)
                    status_next = ST_OVF;
                else
                    res_next = add_sum[ACC_W-1:0];
                state_next = S_DONE;
            end
            S_SUB:
            begin
                res_next   = add_sum[ACC_W-1:0];
                state_next = S_DONE;
            end
            S_MSHIFT:
            begin
                // partial product times ten, then add the multiplicand digit-value times
                work_next = {work_reg[ACC_W-1:0], 4'd0};
                ovf_next  = ovf_reg || (work_next[WORK_W-1 -: 4] != 4'd0);
                rep_next  = src_reg[ACC_W-1 -: 4];
                src_next  = {src_reg[ACC_W-5:0], 4'd0};
                cnt_next  = cnt_reg + 1'b1;
                if (rep_next != 4'd0)
                    state_next = S_MADD;
                else if (cnt_next == CNT_W'(DIGITS))
                begin
                    state_next = S_DONE;
                    if (ovf_next)
                        status_next = ST_OVF;
                    else
                        res_next = work_next[ACC_W-1:0];
                end
            end
            S_MADD:
            begin
                work_next = add_sum;
                ovf_next  = ovf_reg || (add_sum[WORK_W-1 -: 4] != 4'd0);
                rep_next  = rep_reg - 1'b1;
                if (rep_reg == 4'd1)
                begin
                    if (cnt_reg == CNT_W'(DIGITS))
                    begin
                        state_next = S_DONE;
                        if (ovf_next)
                            status_next = ST_OVF;
                        else
                            res_next = work_next[ACC_W-1:0];
                    end
                    else
                        state_next = S_MSHIFT;
                end
            end
            S_DSHIFT:
            begin
                // bring down the next dividend digit
                work_next  = {work_reg[ACC_W-1:0], src_reg[ACC_W-1 -: 4]};
                src_next   = {src_reg[ACC_W-5:0], 4'd0};
                quot_next  = {quot_reg[ACC_W-5:0], 4'd0};
                cnt_next   = cnt_reg + 1'b1;
                state_next = S_DSUB;
            end
            S_DSUB:
            begin
                if (add_cout)
                begin
                    work_next       = add_sum;
                    quot_next[3:0]  = quot_reg[3:0] + 4'd1;
                end
                else if (cnt_reg == CNT_W'(DIGITS))
                begin
                    res_next   = quot_reg;
                    state_next = S_DONE;
                end
                else
                    state_next = S_DSHIFT;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    acc_next   = res_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            acc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg      <= b_next;
        work_reg   <= work_next;
        src_reg    <= src_next;
        quot_reg   <= quot_next;
        rep_reg    <= rep_next;
        cnt_reg    <= cnt_next;
        ovf_reg    <= ovf_next;
        res_reg    <= res_next;
        status_reg <= status_next;
        cmp_reg    <= cmp_next;
    end

    assign idle       = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign res.acc    = res_reg;
    assign res.status = status_reg;
    assign res.cmp    = cmp_reg;
    assign res.zero   = (res_reg == '0);

    `DACC_ASSERT_NOW(a_cmp_onehot, state_reg == S_DONE, $onehot(cmp_reg), "compare flags not one-hot")
    `DACC_ASSERT_NOW(a_neg_is_less, (state_reg == S_DONE) && (status_reg == ST_NEG), cmp_reg[CMP_LT], "negative status without less flag")
    `DACC_ASSERT_NOW(a_cnt_range, (state_reg != S_IDLE) && (state_reg != S_DONE), cnt_reg <= CNT_W'(DIGITS), "digit counter out of range")
    `DACC_ASSERT_NOW(a_quot_digit, state_reg == S_DSUB, quot_reg[3:0] <= 4'd9, "quotient digit above nine")
    `DACC_ASSERT_NEXT(a_acc_hold, !commit, $stable(acc_reg), "accumulator changed outside commit")
endmodule

### test/tb.sv
module tb;
    import dacc_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;
    localparam logic [DATA_W-1:0] BCD_MAX   = 64'h9999_9999_9999_9999;
    localparam int PHASE_WORDS  = 440;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic [DATA_W-1:0] acc;
        logic [STAT_W-1:0] status;
        logic              lt;
        logic              eq;
        logic              gt;
        logic              zero;
    } acc_word_t;

    class acc_scoreboard;
        longint unsigned   acc_num;
        logic [DATA_W-1:0] acc_bcd;
        longint unsigned   limit;
        acc_word_t         pending_q[$];
        int                mismatch_count;
        int                checked_count;
        int                status_tally[4];

        function new();
            acc_num        = 0;
            acc_bcd        = '0;
            mismatch_count = 0;
            checked_count  = 0;
            limit          = 1;
            repeat (DIGITS) limit = limit * 10;
            limit = limit - 1;
            foreach (status_tally[i]) status_tally[i] = 0;
        endfunction

        // nibbles above nine count as zero
        function longint unsigned digits_to_num(input logic [DATA_W-1:0] v);
            longint unsigned n;
            logic [3:0]      d;
            n = 0;
            for (int i = DIGITS - 1; i >= 0; i--)
            begin
                d = v[4*i +: 4];
                if (d > 4'd9)
                    d = 4'd0;
                n = n * 10 + d;
            end
            return n;
        endfunction

        function logic [DATA_W-1:0] num_to_digits(input longint unsigned n);
            logic [DATA_W-1:0] r;
            r = '0;
            for (int i = 0; i < DIGITS; i++)
            begin
                r[4*i +: 4] = 4'(n % 10);
                n = n / 10;
            end
            return r;
        endfunction

        function void note_command(input logic [CMD_W-1:0] c, input logic [DATA_W-1:0] op);
            longint unsigned   a;
            longint unsigned   b;
            longint unsigned   r;
            logic [STAT_W-1:0] st;
            acc_word_t         w;
            a  = acc_num;
            b  = digits_to_num(op);
            r  = a;
            st = ST_OK;
            case (c)
                CMD_LOAD: r = b;
                CMD_ADD:
                begin
                    if (b > limit - a)
                        st = ST_OVF;
                    else
                        r = a + b;
                end
                CMD_SUB:
                begin
                    if (a < b)
                        st = ST_NEG;
                    else
                        r = a - b;
                end
                CMD_MUL:
                begin
                    if (a != 0 && b > limit / a)
                        st = ST_OVF;
                    else
                        r = a * b;
                end
                CMD_DIV:
                begin
                    if (b == 0)
                        st = ST_DIV0;
                    else
                        r = a / b;
                end
                default: ;
            endcase
            acc_num  = r;
            acc_bcd  = num_to_digits(r);
            w.acc    = acc_bcd;
            w.status = st;
            w.lt     = (a < b);
            w.eq     = (a == b);
            w.gt     = (a > b);
            w.zero   = (r == 0);
            status_tally[st]++;
            pending_q = {pending_q, w};
        endfunction

        function void check_result(input logic [DATA_W-1:0] acc, input logic [STAT_W-1:0] st,
                                   input logic lt, input logic eq, input logic gt,
                                   input logic z);
            acc_word_t w;
            if (pending_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result word acc=%h status=%0d", $realtime, acc, st);
                return;
            end
            w = pending_q.pop_front();
            checked_count++;
            if (acc !== w.acc || st !== w.status || lt !== w.lt || eq !== w.eq
                || gt !== w.gt || z !== w.zero)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("%0t: result mismatch", $realtime);
                    $display("  expected acc=%h status=%0d lt/eq/gt=%b%b%b zero=%b",
                             w.acc, w.status, w.lt, w.eq, w.gt, w.zero);
                    $display("  actual   acc=%h status=%0d lt/eq/gt=%b%b%b zero=%b",
                             acc, st, lt, eq, gt, z);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    dacc_in_if  cmd_if ();
    dacc_out_if res_if ();

    decimal_accumulator_alu_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_ch (cmd_if),
        .res_ch (res_if)
    );

    acc_scoreboard sb;
    int            send_idle_pct;
    int            recv_stall_pct;
    bit            hold_req;
    int            words_sent;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    task automatic push_command(input logic [CMD_W-1:0] c, input logic [DATA_W-1:0] op);
        if (send_idle_pct > 0)
        begin
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                cmd_if.valid <= 1'b0;
                @(posedge clk);
            end
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.cmd     <= c;
        cmd_if.operand <= op;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        sb.note_command(c, op);
        words_sent++;
    endtask

    task automatic receive_results();
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (res_if.valid && res_if.ready)
                sb.check_result(res_if.acc_value, res_if.status, res_if.was_less,
                                res_if.was_equal, res_if.was_greater, res_if.acc_zero);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    endtask

    function automatic logic [CMD_W-1:0] pick_cmd();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15) return CMD_LOAD;
        if (roll < 37) return CMD_ADD;
        if (roll < 55) return CMD_SUB;
        if (roll < 70) return CMD_MUL;
        if (roll < 84) return CMD_DIV;
        if (roll < 95) return CMD_CMP;
        if (roll < 98) return CMD_SPARE6;
        return CMD_SPARE7;
    endfunction

    function automatic logic [DATA_W-1:0] pick_operand(input logic [CMD_W-1:0] c);
        logic [DATA_W-1:0] r;
        int                roll;
        int                ndig;
        roll = $urandom_range(0, 99);
        if (roll < 6)
            return {$urandom(), $urandom()};
        if (roll < 11)
            return sb.acc_bcd;
        if (roll < 14)
            return '0;
        if (c == CMD_MUL)
            ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(0, DIGITS) : $urandom_range(1, 4);
        else if (c == CMD_DIV)
            ndig = $urandom_range(1, 6);
        else
            ndig = $urandom_range(0, DIGITS);
        r = '0;
        for (int i = 0; i < ndig; i++)
            r[4*i +: 4] = 4'($urandom_range(0, 9));
        // stray non-decimal digit now and then
        if ($urandom_range(0, 99) < 8)
            r[4*$urandom_range(0, DIGITS - 1) +: 4] = 4'($urandom_range(10, 15));
        return r;
    endfunction

    initial
    begin
        logic [CMD_W-1:0] c;
        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        words_sent     = 0;
        rst_n          = 1'b0;
        cmd_if.valid   <= 1'b0;
        cmd_if.cmd     <= CMD_LOAD;
        cmd_if.operand <= '0;
        res_if.ready   <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        fork
            receive_results();
        join_none

        push_command(CMD_CMP,    '0);
        push_command(CMD_LOAD,   BCD_MAX);
        push_command(CMD_ADD,    64'h1);
        push_command(CMD_ADD,    '0);
        push_command(CMD_MUL,    64'h2);
        push_command(CMD_MUL,    64'h1);
        push_command(CMD_DIV,    '0);
        push_command(CMD_DIV,    BCD_MAX);
        push_command(CMD_SUB,    64'h2);
        push_command(CMD_SUB,    64'h1);
        push_command(CMD_MUL,    BCD_MAX);
        push_command(CMD_LOAD,   64'hFFFF_FFFF_FFFF_FFFF);
        push_command(CMD_LOAD,   64'h1A2B_3C4D_5E6F_7089);
        push_command(CMD_SPARE6, 64'h0000_0000_0000_0500);
        push_command(CMD_SPARE7, 64'hFFFF_FFFF_FFFF_FFFF);
        push_command(CMD_LOAD,   64'h1234_5678);
        push_command(CMD_MUL,    64'h8765_4321);
        push_command(CMD_DIV,    64'h3);
        push_command(CMD_CMP,    BCD_MAX);
        push_command(CMD_SUB,    64'h00C0_0000_0000_1000);
        push_command(CMD_MUL,    '0);
        push_command(CMD_DIV,    64'hA);
        push_command(CMD_LOAD,   64'h9999_9999);
        push_command(CMD_MUL,    64'h9999_9999);
        push_command(CMD_ADD,    64'h1);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (ph == 0 && n == 120)
                    hold_req = 1'b1;
                c = pick_cmd();
                push_command(c, pick_operand(c));
            end
        end
        cmd_if.valid <= 1'b0;

        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d command words sent, %0d result words checked, %0d mismatches",
                 words_sent, sb.checked_count, sb.mismatch_count);
        $display("status mix ok/overflow/negative/div-by-zero: %0d/%0d/%0d/%0d",
                 sb.status_tally[ST_OK], sb.status_tally[ST_OVF],
                 sb.status_tally[ST_NEG], sb.status_tally[ST_DIV0]);
        if (sb.mismatch_count == 0 && sb.pending_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/dacc_pkg.sv
hdl/dacc_in_if.sv
hdl/dacc_out_if.sv
hdl/dacc_bcd_adder.sv
hdl/dacc_core.sv
hdl/decimal_accumulator_alu_unit.sv
test/tb.sv
